[sv/fbfl_pkg.sv]
// Shared types and constants for the fixed block free list allocator.
// No dependencies; imported by fbfl_ctrl, fbfl_dp and the top level.
package fbfl_pkg;

  // Pool geometry: the item fields take their block index width from IDX_W
  localparam int unsigned MAX_BLOCKS = 256;
  localparam int unsigned IDX_W      = 8;
  localparam int unsigned LINK_W     = 9;
  localparam logic [LINK_W-1:0] LINK_NULL = LINK_W'(MAX_BLOCKS);

  // Request kinds
  typedef enum logic {
    KIND_ALLOC   = 1'b0,
    KIND_RELEASE = 1'b1
  } kind_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_POOL = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_IGNORED = 2'd3
  } status_e;

  // Controller states
  typedef enum logic {
    S_IDLE = 1'b0,
    S_POP  = 1'b1
  } state_e;

  // Input item
  typedef struct packed {
    logic             kind;
    logic             block_present;
    logic [IDX_W-1:0] block_index;
  } fbfl_in_t;

  // Result item
  typedef struct packed {
    logic [1:0]       status;
    logic [IDX_W-1:0] granted_index;
  } fbfl_out_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic    pop_rd;    // read the head's link from the link memory
    logic    pop_done;  // advance head to the fetched link
    logic    push;      // link released block in front of head
    logic    load_out;  // capture a result into the output register
    status_e status;    // status of the captured result
  } fbfl_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic created;      // block count nonzero
    logic head_null;    // free list empty
    logic idx_in_range; // released index below block count
  } fbfl_sts_t;

endpackage

[sv/fbfl_ctrl.sv]
// Controller state machine of the free list allocator.
// Depends on fbfl_pkg; drives fbfl_dp through fbfl_cmd_t.
module fbfl_ctrl import fbfl_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  logic      in_kind_i,
  input  logic      in_present_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  fbfl_sts_t sts_i,
  output fbfl_cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;
  logic   in_xfer;

  // Output slot is free when empty or being drained this cycle
  assign slot_free   = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE) && slot_free;
  assign in_xfer     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  // Hold state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Decode requests and sequence pops
  always_comb begin
    state_d = state_q;
    cmd_o   = '{pop_rd: 1'b0, pop_done: 1'b0, push: 1'b0, load_out: 1'b0, status: ST_OK};
    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          if (in_kind_i == KIND_ALLOC) begin
            if (!sts_i.created) begin
              cmd_o.load_out = 1'b1;
              cmd_o.status   = ST_NO_POOL;
            end else if (sts_i.head_null) begin
              cmd_o.load_out = 1'b1;
              cmd_o.status   = ST_EMPTY;
            end else begin
              cmd_o.pop_rd = 1'b1;
              state_d      = S_POP;
            end
          end else begin
            cmd_o.load_out = 1'b1;
            if (!in_present_i) begin
              cmd_o.status = ST_IGNORED;
            end else if (!sts_i.created) begin
              cmd_o.status = ST_NO_POOL;
            end else if (!sts_i.idx_in_range) begin
              cmd_o.status = ST_IGNORED;
            end else begin
              cmd_o.push   = 1'b1;
              cmd_o.status = ST_OK;
            end
          end
        end
      end
      S_POP: begin
        cmd_o.pop_done = 1'b1;
        cmd_o.load_out = 1'b1;
        cmd_o.status   = ST_OK;
        state_d        = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Set on a new result, drop once transferred
  always_comb begin
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else begin
      out_valid_d = out_valid_q && !out_ready_i;
    end
  end

  // A result is captured only into a free slot
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> slot_free)
    else $error("result loaded over a pending result");

  // Every link read is followed by the head update
  a_pop_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.pop_rd |=> cmd_o.pop_done)
    else $error("pop read not completed");

  // Pops only start on a nonempty, created pool
  a_pop_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.pop_rd |-> (sts_i.created && !sts_i.head_null))
    else $error("pop started on empty or missing pool");

endmodule

[sv/fbfl_dp.sv]
// Datapath of the free list allocator: head, block count, link memory,
// written-link flags and output register. Depends on fbfl_pkg.
module fbfl_dp import fbfl_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [LINK_W-1:0] cfg_data_i,
  input  logic [IDX_W-1:0]  in_index_i,
  input  fbfl_cmd_t         cmd_i,
  output fbfl_sts_t         sts_o,
  output fbfl_out_t         out_o
);

  logic [LINK_W-1:0]     count_q;
  logic [LINK_W-1:0]     head_q, head_d;
  logic [MAX_BLOCKS-1:0] link_vld_q;
  logic [LINK_W-1:0]     link_mem [MAX_BLOCKS];
  logic [LINK_W-1:0]     rd_link_q;
  logic                  rd_vld_q;
  logic [LINK_W-1:0]     cfg_count;
  logic [LINK_W-1:0]     head_succ;
  logic [LINK_W-1:0]     fresh_link;
  logic [LINK_W-1:0]     next_head;
  fbfl_out_t             out_q;
  logic [IDX_W-1:0]      head_idx;

  assign head_idx = head_q[IDX_W-1:0];

  // Saturate the written block count
  assign cfg_count = (cfg_data_i > LINK_NULL) ? LINK_NULL : cfg_data_i;

  // Link of a block untouched since the pool was built: its successor
  assign head_succ  = head_q + LINK_W'(1);
  assign fresh_link = (head_succ < count_q) ? head_succ : LINK_NULL;
  assign next_head  = rd_vld_q ? rd_link_q : fresh_link;

  always_comb begin
    head_d = head_q;
    if (cmd_i.push) begin
      head_d = {1'b0, in_index_i};
    end else if (cmd_i.pop_done) begin
      head_d = next_head;
    end
  end

  // Hold count, head and written-link flags; a count write rebuilds the chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      head_q     <= LINK_NULL;
      link_vld_q <= '0;
    end else if (cfg_we_i) begin
      count_q    <= cfg_count;
      head_q     <= (cfg_count == '0) ? LINK_NULL : '0;
      link_vld_q <= '0;
    end else begin
      head_q <= head_d;
      if (cmd_i.push) begin
        link_vld_q[in_index_i] <= 1'b1;
      end
    end
  end

  // Link memory: write on push, registered read on pop
  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      link_mem[in_index_i] <= head_q;
    end
    if (cmd_i.pop_rd) begin
      rd_link_q <= link_mem[head_idx];
      rd_vld_q  <= link_vld_q[head_idx];
    end
  end

  // Capture the result
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_q.status        <= cmd_i.status;
      out_q.granted_index <= cmd_i.pop_done ? head_idx : '0;
    end
  end

  assign out_o = out_q;

  assign sts_o.created      = (count_q != '0);
  assign sts_o.head_null    = (head_q == LINK_NULL);
  assign sts_o.idx_in_range = ({1'b0, in_index_i} < count_q);

  // A pushed block becomes the new head
  a_push_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.push && !cfg_we_i) |=> (head_q == {1'b0, $past(in_index_i)}))
    else $error("pushed block is not the head");

  // Head never exceeds the null code or the block count
  a_head_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (head_q == LINK_NULL) || (head_q < count_q))
    else $error("head outside the pool");

endmodule

[sv/fixed_block_free_list_allocator.sv]
// Top level of the fixed block free list allocator.
// Depends on fbfl_pkg; instantiates fbfl_ctrl and fbfl_dp.
//
// Usage:
//   Request channel (in_valid_i/in_ready_o/in_i) carries allocate or release
//   items; result channel (out_valid_o/out_ready_i/out_o) returns one status
//   and granted index per item. cfg_we_i/cfg_data_i writes the block count,
//   which rebuilds the free list at once (0 tears the pool down); write it
//   only while no item is in flight.
//   Timing: a release or a failed allocate has its result valid in the cycle
//   after the transfer; a successful allocate first passes through S_POP, as
//   the head's link comes from the link memory through a registered read.
//   Throughput: one item per cycle for releases and failed allocates while
//   the result channel does not stall; no request is taken while in S_POP.
//   Links of blocks not released since the last count write are implied by
//   a per-block flag, so the rebuild takes no sweep.
//   Reset: no pool, empty list, no result pending.
//   Stall: a result waits in the output register; the next request is
//   taken in the cycle that result is transferred.
module fixed_block_free_list_allocator import fbfl_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  fbfl_in_t          in_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output fbfl_out_t         out_o,
  input  logic              cfg_we_i,
  input  logic [LINK_W-1:0] cfg_data_i
);

  fbfl_cmd_t cmd;
  fbfl_sts_t sts;

  // Sequence requests
  fbfl_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_kind_i    (in_i.kind),
    .in_present_i (in_i.block_present),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .sts_i        (sts),
    .cmd_o        (cmd)
  );

  // Hold the free list
  fbfl_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .in_index_i (in_i.block_index),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_o      (out_o)
  );

endmodule
